/* rtl/wamm_pkg.sv */
// shared types, constants and helpers of the windowed average min/max tracker
// no dependencies
`default_nettype none

package wamm_pkg;

	localparam int CHANNELS_DEF = 64;
	localparam int SAMPLE_BITS  = 12;
	localparam int CH_W         = 6;
	localparam int TIME_W       = 32;
	localparam int SUM_W        = 32;
	localparam int COUNT_W      = 20;
	localparam int INTERVAL_W   = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int REM_W        = SUM_W - SAMPLE_BITS;
	localparam int DIV_STEPS    = SAMPLE_BITS;
	localparam int STEP_W       = $clog2(DIV_STEPS);

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
	localparam logic [COUNT_W-1:0]     COUNT_MAX  = {COUNT_W{1'b1}};
	localparam logic [SUM_W-1:0]       SUM_MAX    = {SUM_W{1'b1}};

	localparam logic [INTERVAL_W-1:0]  INTERVAL_RST  = INTERVAL_W'(500);
	localparam logic [SAMPLE_BITS-1:0] MAX_START_RST = '0;
	localparam logic [SAMPLE_BITS-1:0] MIN_START_RST = SAMPLE_MAX;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_INTERVAL = 2'd0,
		CFG_MAX_START       = 2'd1,
		CFG_MIN_START       = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                   func;
		logic [CH_W-1:0]        channel;
		logic [SAMPLE_BITS-1:0] sample;
		logic [TIME_W-1:0]      time_ms;
		logic                   scan_end;
	} req_t;

	typedef struct packed {
		logic [CH_W-1:0]        out_channel;
		logic                   window_closed;
		logic [SAMPLE_BITS-1:0] average;
		logic [SAMPLE_BITS-1:0] key_max;
		logic [SAMPLE_BITS-1:0] key_min;
	} rsp_t;

	function automatic int addr_w(int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

`default_nettype wire

/* rtl/wamm_ram.sv */
// generic single write port, single read port ram with registered read data
// uses wamm_pkg for the address width helper
`default_nettype none

module wamm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [wamm_pkg::addr_w(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]                    wdata,
	input  wire logic                                re,
	input  wire logic [wamm_pkg::addr_w(DEPTH)-1:0]  raddr,
	output logic      [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/windowed_average_min_max_tracker_top.sv */
// windowed average min/max tracker: per-channel sums and limits in two rams
// depends on wamm_pkg and wamm_ram
//
// usage:
// - req channel: one transaction per sample (func 0) or calibration start
//   (func 1), accepted when req_valid is high and req_stall is low
// - rsp channel: one transaction per request, taken when rsp_valid is high
//   and rsp_stall is low; rsp is held while stalled
// - cfg channel: register writes (index, data), always ready; write only
//   while the block is idle
// - one request is in work at a time; req_stall is high from acceptance
//   until its result enters the output register
// - a request that closes no window passes the read and done states; its
//   result is registered in done, and the next request is taken back in idle
// - a request that closes a window runs the 12-step radix-2 divider through
//   the load and div states before done, where its result is registered
// - a stalled result keeps its register; the next request is still worked on
//   and waits at the end until the output register frees up
// - reset clears sums, limits, scan count and window start time at once
//   (per-entry valid bits), so no clearing pass is needed
`default_nettype none

module windowed_average_min_max_tracker_top #(
	parameter int CHANNELS = wamm_pkg::CHANNELS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire wamm_pkg::req_t                      req,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output wamm_pkg::rsp_t                           rsp,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [wamm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [wamm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW    = wamm_pkg::addr_w(CHANNELS);
	localparam int SB    = wamm_pkg::SAMPLE_BITS;
	localparam int SUM_W = wamm_pkg::SUM_W;
	localparam int CNT_W = wamm_pkg::COUNT_W;
	localparam int REM_W = wamm_pkg::REM_W;
	localparam int CH_W  = wamm_pkg::CH_W;

	wamm_pkg::state_t state_q, state_nxt;

	// configuration
	logic [wamm_pkg::INTERVAL_W-1:0] interval_q;
	logic [SB-1:0]                   max_start_q, min_start_q;
	logic [SB-1:0]                   base_max_q, base_min_q;

	// global window state
	logic [CNT_W-1:0]              scan_count_q;
	logic [wamm_pkg::TIME_W-1:0]   win_start_q;
	logic [CHANNELS-1:0]           sum_vld_q, lim_vld_q;

	// item and stage registers
	wamm_pkg::req_t   item_q;
	logic [SUM_W-1:0] sum_s2;
	logic             due_s2;
	logic [CNT_W-1:0] div_s2;
	logic [SB-1:0]    lim_max_s2, lim_min_s2;

	// divider
	logic [REM_W-1:0]            rem_q;
	logic [SB-1:0]               dvd_q, quo_q;
	logic [wamm_pkg::STEP_W-1:0] step_q;
	logic                        sat_q;

	wamm_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	// control
	logic accept, rsp_load, out_free, go_div, div_last;
	logic sum_we, lim_we;

	// memory ports
	logic [SUM_W-1:0] sum_rdata, sum_wdata;
	logic [2*SB-1:0]  lim_rdata, lim_wdata;
	logic [AW-1:0]    req_idx, item_idx;
	logic [AW+CH_W-1:0] req_idx_ext, item_idx_ext;

	// datapath
	logic             in_range, cur_vld_sum, cur_vld_lim, closed;
	logic [SUM_W-1:0] sum_rd;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_add;
	logic [wamm_pkg::TIME_W-1:0] elapsed;
	logic             due;
	logic [CNT_W-1:0] divisor;
	logic [SB-1:0]    rd_max, rd_min;
	logic [REM_W:0]   trial, trial_sub;
	logic             trial_ge;
	logic [SB-1:0]    avg, new_max, new_min;

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign req_idx_ext  = {{AW{1'b0}}, req.channel};
	assign req_idx      = req_idx_ext[AW-1:0];
	assign item_idx_ext = {{AW{1'b0}}, item_q.channel};
	assign item_idx     = item_idx_ext[AW-1:0];
	assign in_range     = 32'(item_q.channel) < 32'(CHANNELS);

	assign out_free = !rsp_valid_q || !rsp_stall;

	// read stage arithmetic
	always_comb begin
		cur_vld_sum = in_range ? sum_vld_q[item_idx] : 1'b0;
		cur_vld_lim = in_range ? lim_vld_q[item_idx] : 1'b0;
		sum_rd      = cur_vld_sum ? sum_rdata : '0;
		sum_wide    = {1'b0, sum_rd} + (SUM_W+1)'(item_q.sample);
		sum_add     = sum_wide[SUM_W] ? wamm_pkg::SUM_MAX : sum_wide[SUM_W-1:0];
		elapsed     = item_q.time_ms - win_start_q;
		due         = elapsed >= wamm_pkg::TIME_W'(interval_q);
		divisor     = (scan_count_q == wamm_pkg::COUNT_MAX) ? wamm_pkg::COUNT_MAX
			: scan_count_q + CNT_W'(1);
		rd_max      = cur_vld_lim ? lim_rdata[2*SB-1:SB] : base_max_q;
		rd_min      = cur_vld_lim ? lim_rdata[SB-1:0] : base_min_q;
		go_div      = !item_q.func && in_range && due;
	end

	// divider step
	always_comb begin
		trial     = {rem_q, dvd_q[SB-1]};
		trial_ge  = trial >= (REM_W+1)'(div_s2);
		trial_sub = trial - (REM_W+1)'(div_s2);
		div_last  = step_q == wamm_pkg::STEP_W'(wamm_pkg::DIV_STEPS - 1);
	end

	// finishing values
	always_comb begin
		closed = !item_q.func && in_range && due_s2;
		avg    = closed ? (sat_q ? wamm_pkg::SAMPLE_MAX : quo_q) : '0;
		if (!in_range) begin
			new_max = '0;
			new_min = '0;
		end else if (item_q.func) begin
			new_max = max_start_q;
			new_min = min_start_q;
		end else if (closed) begin
			new_max = (lim_max_s2 < avg) ? avg : lim_max_s2;
			new_min = (lim_min_s2 > avg) ? avg : lim_min_s2;
		end else begin
			new_max = lim_max_s2;
			new_min = lim_min_s2;
		end
		sum_wdata = closed ? '0 : sum_s2;
		lim_wdata = {new_max, new_min};
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			wamm_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nxt = wamm_pkg::ST_READ;
				end
			end
			wamm_pkg::ST_READ: begin
				state_nxt = go_div ? wamm_pkg::ST_LOAD : wamm_pkg::ST_DONE;
			end
			wamm_pkg::ST_LOAD: begin
				state_nxt = wamm_pkg::ST_DIV;
			end
			wamm_pkg::ST_DIV: begin
				if (div_last) begin
					state_nxt = wamm_pkg::ST_DONE;
				end
			end
			wamm_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = wamm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = wamm_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_stall = 1'b1;
		accept    = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			wamm_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				accept    = req_valid;
			end
			wamm_pkg::ST_DONE: begin
				rsp_load = out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
		sum_we = rsp_load && !item_q.func && in_range;
		lim_we = rsp_load && closed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wamm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= wamm_pkg::INTERVAL_RST;
			max_start_q <= wamm_pkg::MAX_START_RST;
			min_start_q <= wamm_pkg::MIN_START_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (wamm_pkg::cfg_reg_t'(cfg_index))
				wamm_pkg::CFG_WINDOW_INTERVAL: interval_q  <= cfg_data;
				wamm_pkg::CFG_MAX_START:       max_start_q <= cfg_data[SB-1:0];
				wamm_pkg::CFG_MIN_START:       min_start_q <= cfg_data[SB-1:0];
				default: begin
				end
			endcase
		end
	end

	// window state, entry valid bits and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_count_q <= '0;
			win_start_q  <= '0;
			sum_vld_q    <= '0;
			lim_vld_q    <= '0;
			base_max_q   <= '0;
			base_min_q   <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (rsp_load && item_q.func) begin
				lim_vld_q  <= '0;
				base_max_q <= max_start_q;
				base_min_q <= min_start_q;
			end
			if (sum_we) begin
				sum_vld_q[item_idx] <= 1'b1;
			end
			if (lim_we) begin
				lim_vld_q[item_idx] <= 1'b1;
			end
			if (rsp_load && !item_q.func && item_q.scan_end) begin
				if (due_s2) begin
					scan_count_q <= '0;
					win_start_q  <= item_q.time_ms;
				end else if (scan_count_q != wamm_pkg::COUNT_MAX) begin
					scan_count_q <= scan_count_q + CNT_W'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (state_q == wamm_pkg::ST_READ) begin
			sum_s2     <= sum_add;
			due_s2     <= due;
			div_s2     <= divisor;
			lim_max_s2 <= rd_max;
			lim_min_s2 <= rd_min;
			sat_q      <= 1'b0;
			quo_q      <= '0;
		end
		if (state_q == wamm_pkg::ST_LOAD) begin
			rem_q  <= sum_s2[SUM_W-1:SB];
			dvd_q  <= sum_s2[SB-1:0];
			quo_q  <= '0;
			step_q <= '0;
			sat_q  <= sum_s2[SUM_W-1:SB] >= REM_W'(div_s2);
		end
		if (state_q == wamm_pkg::ST_DIV) begin
			rem_q  <= trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
			dvd_q  <= {dvd_q[SB-2:0], 1'b0};
			quo_q  <= {quo_q[SB-2:0], trial_ge};
			step_q <= step_q + wamm_pkg::STEP_W'(1);
		end
		if (rsp_load) begin
			rsp_q.out_channel   <= item_q.channel;
			rsp_q.window_closed <= closed;
			rsp_q.average       <= avg;
			rsp_q.key_max       <= new_max;
			rsp_q.key_min       <= new_min;
		end
	end

	wamm_ram #(
		.WIDTH (SUM_W),
		.DEPTH (CHANNELS)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (item_idx),
		.wdata (sum_wdata),
		.re    (accept),
		.raddr (req_idx),
		.rdata (sum_rdata)
	);

	wamm_ram #(
		.WIDTH (2*SB),
		.DEPTH (CHANNELS)
	) u_lim_ram (
		.clk   (clk),
		.we    (lim_we),
		.waddr (item_idx),
		.wdata (lim_wdata),
		.re    (accept),
		.raddr (req_idx),
		.rdata (lim_rdata)
	);

endmodule

`default_nettype wire

/* rtl/wamm_checker.sv */
// port-level checks of the windowed average min/max tracker and their bind
// depends on wamm_pkg and windowed_average_min_max_tracker_top
`default_nettype none

module wamm_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire wamm_pkg::rsp_t rsp
);

	// stalled result transaction stays
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("result changed while stalled");

	// one request in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in work");

	// no average without a closed window
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.window_closed |-> rsp.average == '0)
		else $error("average without closed window");

	// limits enclose a fresh average
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.window_closed |->
			rsp.key_max >= rsp.average && rsp.key_min <= rsp.average)
		else $error("limits do not enclose the average");

endmodule

bind windowed_average_min_max_tracker_top wamm_checker u_wamm_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench of the windowed average min/max tracker: directed and random scans
// with its own per-channel sum/limit tracker; depends on wamm_pkg and the tracker top level

module tb_top;

	localparam int NCH         = wamm_pkg::CHANNELS_DEF;
	localparam int SAMPLE_BITS = wamm_pkg::SAMPLE_BITS;
	localparam int SUM_W       = wamm_pkg::SUM_W;
	localparam int COUNT_W     = wamm_pkg::COUNT_W;
	localparam int TIME_W      = wamm_pkg::TIME_W;
	localparam int INTERVAL_W  = wamm_pkg::INTERVAL_W;
	localparam int CH_W        = wamm_pkg::CH_W;
	localparam int CFG_IDX_W   = wamm_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = wamm_pkg::CFG_DATA_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	wamm_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	wamm_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = wamm_pkg::CFG_WINDOW_INTERVAL;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	windowed_average_min_max_tracker_top #(.CHANNELS(NCH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// tracker state mirrored on the testbench side
	logic [SUM_W-1:0]       ch_sum [NCH];
	logic [SAMPLE_BITS-1:0] ch_max [NCH];
	logic [SAMPLE_BITS-1:0] ch_min [NCH];
	logic [COUNT_W-1:0]     scans_in_window = '0;
	logic [TIME_W-1:0]      window_opened_at = '0;
	logic [INTERVAL_W-1:0]  cur_interval = wamm_pkg::INTERVAL_RST;
	logic [SAMPLE_BITS-1:0] cur_max_start = wamm_pkg::MAX_START_RST;
	logic [SAMPLE_BITS-1:0] cur_min_start = wamm_pkg::MIN_START_RST;

	wamm_pkg::req_t pending_req[$];
	wamm_pkg::rsp_t expected_rsp[$];
	wamm_pkg::rsp_t want_rsp;
	bit failed = 1'b0;
	bit req_taken = 1'b0;
	bit calm = 1'b0;
	bit [7:0] calm_cnt = '0;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	int gap_left = 0;
	logic [TIME_W-1:0] scan_time = '0;

	function automatic wamm_pkg::rsp_t track_item(wamm_pkg::req_t it);
		wamm_pkg::rsp_t r;
		logic [SUM_W:0] acc;
		logic [SUM_W-1:0] divisor;
		logic [SUM_W-1:0] quot;
		bit due;
		r = '0;
		r.out_channel = it.channel;
		if (it.func) begin
			for (int i = 0; i < NCH; i++) begin
				ch_max[i] = cur_max_start;
				ch_min[i] = cur_min_start;
			end
		end else begin
			due = (it.time_ms - window_opened_at) >= TIME_W'(cur_interval);
			acc = {1'b0, ch_sum[it.channel]} + (SUM_W + 1)'(it.sample);
			if (acc[SUM_W])
				acc = {1'b0, wamm_pkg::SUM_MAX};
			if (due) begin
				divisor = (scans_in_window == wamm_pkg::COUNT_MAX) ?
					SUM_W'(wamm_pkg::COUNT_MAX) : SUM_W'(scans_in_window) + SUM_W'(1);
				quot = acc[SUM_W-1:0] / divisor;
				r.average = (quot > SUM_W'(wamm_pkg::SAMPLE_MAX)) ? wamm_pkg::SAMPLE_MAX :
					quot[SAMPLE_BITS-1:0];
				r.window_closed = 1'b1;
				acc = '0;
				if (ch_max[it.channel] < r.average)
					ch_max[it.channel] = r.average;
				if (ch_min[it.channel] > r.average)
					ch_min[it.channel] = r.average;
			end
			ch_sum[it.channel] = acc[SUM_W-1:0];
			if (it.scan_end) begin
				if (due) begin
					scans_in_window = '0;
					window_opened_at = it.time_ms;
				end else if (scans_in_window != wamm_pkg::COUNT_MAX) begin
					scans_in_window = scans_in_window + COUNT_W'(1);
				end
			end
		end
		r.key_max = ch_max[it.channel];
		r.key_min = ch_min[it.channel];
		return r;
	endfunction

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		calm_cnt <= calm_cnt + 8'(1);
		if (calm_cnt == 8'hFF)
			calm <= ($urandom_range(0, 3) == 0);
	end

	// input side: predict at acceptance, track register writes
	always @(posedge clk) begin
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall)
			expected_rsp.push_back(track_item(req));
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				wamm_pkg::CFG_WINDOW_INTERVAL: cur_interval = cfg_data[INTERVAL_W-1:0];
				wamm_pkg::CFG_MAX_START: cur_max_start = cfg_data[SAMPLE_BITS-1:0];
				wamm_pkg::CFG_MIN_START: cur_min_start = cfg_data[SAMPLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (req_valid && !calm)
				gap_left = pick_idle();
			if (gap_left == 0 && pending_req.size() != 0) begin
				req <= pending_req.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end
		end
	end

	// receiver stall, with a long hold on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 300;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			if (!calm)
				stall_left = pick_idle();
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("result transaction with none expected: out_channel %0d", rsp.out_channel);
				failed = 1'b1;
			end else begin
				want_rsp = expected_rsp.pop_front();
				if (rsp.out_channel !== want_rsp.out_channel) begin
					$error("out_channel: expected %0d, got %0d", want_rsp.out_channel,
						rsp.out_channel);
					failed = 1'b1;
				end
				if (rsp.window_closed !== want_rsp.window_closed) begin
					$error("window_closed: expected %0d, got %0d", want_rsp.window_closed,
						rsp.window_closed);
					failed = 1'b1;
				end
				if (rsp.average !== want_rsp.average) begin
					$error("average: expected %0d, got %0d", want_rsp.average, rsp.average);
					failed = 1'b1;
				end
				if (rsp.key_max !== want_rsp.key_max) begin
					$error("key_max: expected %0d, got %0d", want_rsp.key_max, rsp.key_max);
					failed = 1'b1;
				end
				if (rsp.key_min !== want_rsp.key_min) begin
					$error("key_min: expected %0d, got %0d", want_rsp.key_min, rsp.key_min);
					failed = 1'b1;
				end
			end
		end
	end

	task automatic push_item(bit f, logic [CH_W-1:0] ch, logic [SAMPLE_BITS-1:0] s,
			logic [TIME_W-1:0] t, bit last);
		wamm_pkg::req_t it;
		it.func = f;
		it.channel = ch;
		it.sample = s;
		it.time_ms = t;
		it.scan_end = last;
		pending_req.push_back(it);
	endtask

	task automatic drain();
		while (pending_req.size() != 0 || req_valid)
			@(negedge clk);
		while (expected_rsp.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(wamm_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic gen_scans(int n, int unsigned iv);
		int made;
		int len;
		int r;
		logic [CH_W-1:0] base;
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				push_item(1'b1, CH_W'($urandom()), SAMPLE_BITS'($urandom()), $urandom(),
					1'($urandom()));
				made++;
			end else if (r < 12) begin
				push_item(1'b0, CH_W'($urandom()), SAMPLE_BITS'($urandom()),
					($urandom_range(0, 1) == 0) ? scan_time : TIME_W'($urandom()),
					1'($urandom()));
				made++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60)
					scan_time = scan_time + $urandom_range(0, iv / 3 + 1);
				else if (r < 90)
					scan_time = scan_time + $urandom_range(0, iv + iv / 2 + 50);
				else
					scan_time = scan_time + $urandom();
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, NCH) : $urandom_range(1, 8);
				base = ($urandom_range(0, 1) == 0) ? '0 : CH_W'($urandom());
				for (int k = 0; k < len; k++)
					push_item(1'b0, base + CH_W'(k), SAMPLE_BITS'($urandom()), scan_time,
						(k == len - 1) && ($urandom_range(0, 9) != 0));
				made += len;
			end
		end
	endtask

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < NCH; i++) begin
			ch_sum[i] = '0;
			ch_max[i] = '0;
			ch_min[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items under reset register values
		push_item(1'b0, 6'd0, 12'd0, 32'd0, 1'b0);
		push_item(1'b1, 6'd63, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
		push_item(1'b0, 6'd63, 12'hFFF, 32'd100, 1'b0);
		push_item(1'b0, 6'd5, 12'hFFF, 32'd100, 1'b0);
		push_item(1'b0, 6'd5, 12'hFFF, 32'd100, 1'b1);
		// average above the sample range saturates
		push_item(1'b0, 6'd5, 12'hFFF, 32'd600, 1'b0);
		push_item(1'b0, 6'd63, 12'd1, 32'd600, 1'b1);
		push_item(1'b0, 6'd0, 12'd2730, 32'd700, 1'b1);
		// elapsed time exactly equal to the interval
		push_item(1'b0, 6'd0, 12'd0, 32'd1100, 1'b1);
		// time wraps past 2^32
		push_item(1'b0, 6'd42, 12'd1234, 32'hFFFF_FFF0, 1'b1);
		push_item(1'b0, 6'd42, 12'd21, 32'h0000_0100, 1'b1);
		push_item(1'b0, 6'd42, 12'd2048, 32'h0000_0300, 1'b1);
		push_item(1'b0, 6'd21, 12'd3000, 32'h8000_0000, 1'b0);
		push_item(1'b1, 6'd21, 12'd0, 32'd0, 1'b0);
		push_item(1'b0, 6'd63, 12'd0, 32'h8000_0000, 1'b1);
		push_item(1'b0, 6'd21, 12'd77, 32'h8000_0000, 1'b1);
		scan_time = 32'h8000_0000;
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			int unsigned iv;
			case (ph)
				0: begin
					iv = 0;
					write_reg(wamm_pkg::CFG_WINDOW_INTERVAL, 16'h0000);
					write_reg(wamm_pkg::CFG_MAX_START, 16'hFFFF);
					write_reg(wamm_pkg::CFG_MIN_START, 16'hF000);
				end
				1: begin
					iv = 65535;
					write_reg(wamm_pkg::CFG_WINDOW_INTERVAL, 16'hFFFF);
					write_reg(wamm_pkg::CFG_MAX_START, 16'h0000);
					write_reg(wamm_pkg::CFG_MIN_START, 16'h0FFF);
				end
				2: begin
					iv = 1;
					write_reg(wamm_pkg::CFG_WINDOW_INTERVAL, 16'h0001);
					write_reg(wamm_pkg::CFG_MAX_START, 16'($urandom()));
					write_reg(wamm_pkg::CFG_MIN_START, 16'($urandom()));
				end
				3: begin
					iv = $urandom_range(100, 1000);
					write_reg(wamm_pkg::CFG_WINDOW_INTERVAL, 16'(iv));
					write_reg(wamm_pkg::CFG_MAX_START, 16'($urandom()));
					write_reg(wamm_pkg::CFG_MIN_START, 16'($urandom()));
				end
				default: begin
					iv = 500;
					scan_time = 32'hFFFF_0000 + $urandom_range(0, 255);
					write_reg(wamm_pkg::CFG_WINDOW_INTERVAL, 16'd500);
					write_reg(wamm_pkg::CFG_MAX_START, 16'($urandom()));
					write_reg(wamm_pkg::CFG_MIN_START, 16'($urandom()));
				end
			endcase
			push_item(1'b1, CH_W'($urandom()), SAMPLE_BITS'($urandom()), scan_time, 1'b0);
			if (ph == 3) begin
				gen_scans(120, iv);
				@(posedge clk);
				hold_req = !hold_req;
				drain();
				gen_scans(125, iv);
			end else begin
				gen_scans(245, iv);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
